// ===== hw/rtl/nwsb_pkg.sv =====
// Shared types and constants for the narrow write shadow bridge.
package nwsb_pkg;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic [7:0] ADDR_BLK_SIZE  = 8'h04;
   localparam logic [7:0] ADDR_BLK_COUNT = 8'h06;
   localparam logic [7:0] ADDR_XFER_MODE = 8'h0C;
   localparam logic [7:0] ADDR_COMMAND   = 8'h0E;

   typedef enum logic [2:0] {
      CLS_READ,
      CLS_WR_BYTE,
      CLS_WR_HALF,
      CLS_WR_XFER,
      CLS_WR_BLOCK,
      CLS_WR_CMD,
      CLS_WR_WORD
   } op_class_type;

   typedef struct packed {
      op_class_type cls;
      logic [1:0]   size;
      logic [7:0]   waddr;
      logic [4:0]   shift;
      logic [31:0]  wdata;
   } op_type;

endpackage

// ===== hw/rtl/nwsb_front.sv =====
// Front end: accepts bus accesses and classifies them into queue entries.
module nwsb_front import nwsb_pkg::*; (
   input  logic        q_full,
   input  logic        clearing,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [1:0]  req_access_size,
   input  logic [7:0]  req_byte_addr,
   input  logic [31:0] req_write_data,
   output logic        push,
   output op_type      push_op
);

   logic [1:0]   size_norm;
   op_class_type cls;

   assign busy = q_full | clearing;
   assign push = start & ~busy;

   // Size code three behaves as a word access.
   assign size_norm = (req_access_size == 2'd3) ? SIZE_WORD : req_access_size;

   always_comb begin
      cls = CLS_READ;
      if (req_cmd) begin
         unique case (size_norm)
            SIZE_BYTE: cls = CLS_WR_BYTE;
            SIZE_HALF: begin
               if (req_byte_addr == ADDR_COMMAND) begin
                  cls = CLS_WR_CMD;
               end else if (req_byte_addr == ADDR_XFER_MODE) begin
                  cls = CLS_WR_XFER;
               end else if (req_byte_addr == ADDR_BLK_SIZE ||
                            req_byte_addr == ADDR_BLK_COUNT) begin
                  cls = CLS_WR_BLOCK;
               end else begin
                  cls = CLS_WR_HALF;
               end
            end
            default: cls = CLS_WR_WORD;
         endcase
      end
   end

   assign push_op.cls   = cls;
   assign push_op.size  = size_norm;
   assign push_op.waddr = {req_byte_addr[7:2], 2'b00};
   assign push_op.shift = {req_byte_addr[1:0], 3'b000};
   assign push_op.wdata = req_write_data;

endmodule

// ===== hw/rtl/nwsb_queue.sv =====
// Two-entry queue of classified accesses between the front end and the executor.
module nwsb_queue import nwsb_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type head_op,
   output logic   full,
   output logic   empty
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);

   op_type          q_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW:0]     count_ff;
   logic [PW:0]     count_in;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

endmodule

// ===== hw/rtl/nwsb_back.sv =====
// Executor: holds the register window and the shadows, and issues the word results.
module nwsb_back import nwsb_pkg::*; #(
   parameter int WINDOW_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  op_type      head_op,
   output logic        pop,
   output logic        clearing,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [7:0]  rsp_word_addr,
   output logic [31:0] rsp_data,
   output logic        rsp_last
);

   localparam int IW = $clog2(WINDOW_WORDS);
   localparam int AW = (IW > 6) ? IW : 6;
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_CMD
   } state_type;

   function automatic logic [IW-1:0] word_index(input logic [7:0] waddr);
      logic [AW-1:0] wide;
      wide = AW'(waddr[7:2]);
      return wide[IW-1:0];
   endfunction

   function automatic logic [31:0] merge(input logic [31:0] old, input logic [31:0] val,
                                         input logic [31:0] mask, input logic [4:0] shift);
      logic [31:0] m;
      m = mask << shift;
      return (old & ~m) | ((val & mask) << shift);
   endfunction

   logic [31:0] mem [WINDOW_WORDS];
   logic [31:0] mem_rd_ff;
   logic        mem_we;
   logic [IW-1:0] mem_widx;
   logic [31:0] mem_wdata;

   state_type   state_ff;
   op_type      op_ff;
   logic [IW-1:0] clr_cnt_ff;
   logic [31:0] blk_shadow_ff;
   logic [31:0] cmd_shadow_ff;
   logic        pending_ff;
   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_word_addr_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic        in_win;
   logic [IW-1:0] op_idx;
   logic [31:0] win_word;
   logic [31:0] half_old;
   logic [31:0] nv_half;
   logic [31:0] nv_byte;
   logic [31:0] half_src;
   logic [31:0] rd_value;
   logic        flush_now;
   logic [31:0] exec_data;

   assign pop      = (state_ff == ST_IDLE) && !q_empty;
   assign clearing = (state_ff == ST_CLEAR);

   // Words past the end of the window read as zero and drop writes.
   assign in_win   = 32'(op_ff.waddr[7:2]) < 32'(WINDOW_WORDS);
   assign op_idx   = word_index(op_ff.waddr);
   assign win_word = in_win ? mem_rd_ff : 32'd0;

   always_comb begin
      if (op_ff.cls == CLS_WR_CMD) begin
         half_old = cmd_shadow_ff;
      end else if (op_ff.cls == CLS_WR_BLOCK) begin
         half_old = blk_shadow_ff;
      end else begin
         half_old = win_word;
      end
   end

   assign nv_half  = merge(half_old, op_ff.wdata, 32'h0000_FFFF, op_ff.shift);
   assign nv_byte  = merge(win_word, op_ff.wdata, 32'h0000_00FF, op_ff.shift);
   assign half_src = (pending_ff && op_ff.waddr == ADDR_XFER_MODE) ? cmd_shadow_ff : win_word;

   always_comb begin
      case (op_ff.size)
         SIZE_BYTE: rd_value = (win_word >> op_ff.shift) & 32'h0000_00FF;
         SIZE_HALF: rd_value = (half_src >> op_ff.shift) & 32'h0000_FFFF;
         default:   rd_value = win_word;
      endcase
   end

   assign flush_now = (op_ff.cls == CLS_WR_CMD) && (blk_shadow_ff != 32'd0);

   always_comb begin
      case (op_ff.cls)
         CLS_READ:    exec_data = rd_value;
         CLS_WR_BYTE: exec_data = nv_byte;
         CLS_WR_WORD: exec_data = op_ff.wdata;
         default:     exec_data = flush_now ? blk_shadow_ff : nv_half;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_widx  = op_idx;
      mem_wdata = nv_half;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_widx  = clr_cnt_ff;
            mem_wdata = 32'd0;
         end
         ST_EXEC: begin
            unique case (op_ff.cls)
               CLS_WR_BYTE: begin
                  mem_we    = in_win;
                  mem_wdata = nv_byte;
               end
               CLS_WR_HALF: mem_we = in_win;
               CLS_WR_WORD: begin
                  mem_we    = in_win;
                  mem_wdata = op_ff.wdata;
               end
               CLS_WR_CMD: begin
                  mem_we = 1'b1;
                  if (blk_shadow_ff != 32'd0) begin
                     mem_widx  = word_index(ADDR_BLK_SIZE);
                     mem_wdata = blk_shadow_ff;
                  end
               end
               default: mem_we = 1'b0;
            endcase
         end
         ST_CMD:  mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   // The read port follows the queue head, so the word is ready when its access executes.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_widx] <= mem_wdata;
      end
      mem_rd_ff <= mem[word_index(head_op.waddr)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         blk_shadow_ff <= '0;
         cmd_shadow_ff <= '0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               rsp_valid_ff <= 1'b0;
               clr_cnt_ff   <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == IW'(WINDOW_WORDS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (!q_empty) begin
                  op_ff    <= head_op;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff         <= flush_now ? ST_CMD : ST_IDLE;
               rsp_valid_ff     <= !(op_ff.cls inside {CLS_WR_XFER, CLS_WR_BLOCK});
               rsp_kind_ff      <= (op_ff.cls == CLS_READ) ? KIND_READ : KIND_WRITE;
               rsp_word_addr_ff <= flush_now ? ADDR_BLK_SIZE : op_ff.waddr;
               rsp_data_ff      <= exec_data;
               rsp_last_ff      <= !flush_now;
               unique case (op_ff.cls)
                  CLS_WR_HALF: pending_ff <= 1'b0;
                  CLS_WR_XFER: begin
                     cmd_shadow_ff <= nv_half;
                     pending_ff    <= 1'b1;
                  end
                  CLS_WR_BLOCK: blk_shadow_ff <= nv_half;
                  CLS_WR_CMD: begin
                     if (flush_now) begin
                        // Flush the block shadow first; the command word follows.
                        blk_shadow_ff <= '0;
                     end else begin
                        pending_ff <= 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            ST_CMD: begin
               rsp_valid_ff     <= 1'b1;
               rsp_kind_ff      <= KIND_WRITE;
               rsp_word_addr_ff <= op_ff.waddr;
               rsp_data_ff      <= nv_half;
               rsp_last_ff      <= 1'b1;
               pending_ff       <= 1'b0;
               state_ff         <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_word_addr = rsp_word_addr_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_last      = rsp_last_ff;

   a_flush_then_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |=> rsp_valid_ff && rsp_last_ff &&
                                       rsp_word_addr_ff == ADDR_XFER_MODE)
      else $error("block flush not followed by the command word");

   a_no_rsp_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result issued during window clearing");

   a_read_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_READ |-> rsp_last_ff)
      else $error("read result not marked last");

endmodule

// ===== hw/rtl/narrow_write_shadow_bridge.sv =====
// Top level of the narrow write shadow bridge: front end, queue and executor.
//
// After reset the bridge clears its register window, one word a cycle, with
// busy high. An access is taken when start is high and busy is low, classified
// and queued (two entries), so accesses are taken while the executor is busy
// until the queue is full. The executor reads the window word through a
// register, then merges and writes it; a command halfword that flushes the
// block shadow adds a state for the command word. Result words are registered;
// a flushed command gives two words on consecutive cycles, the last one with
// rsp_last high. Shadowed halfword writes give no word. Each result word is
// present for exactly one cycle: the receiver cannot stall.
module narrow_write_shadow_bridge import nwsb_pkg::*; #(
   parameter int WINDOW_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [1:0]  req_access_size,
   input  logic [7:0]  req_byte_addr,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [7:0]  rsp_word_addr,
   output logic [31:0] rsp_data,
   output logic        rsp_last
);

   logic   q_full;
   logic   q_empty;
   logic   clearing;
   logic   push;
   logic   pop;
   op_type push_op;
   op_type head_op;

   nwsb_front u_front (
      .q_full          (q_full),
      .clearing        (clearing),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_access_size (req_access_size),
      .req_byte_addr   (req_byte_addr),
      .req_write_data  (req_write_data),
      .push            (push),
      .push_op         (push_op)
   );

   nwsb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   nwsb_back #(
      .WINDOW_WORDS (WINDOW_WORDS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .head_op       (head_op),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_word_addr (rsp_word_addr),
      .rsp_data      (rsp_data),
      .rsp_last      (rsp_last)
   );

endmodule
